// ===== rtl/interpolated_fractional_delay_top_defines.svh =====
// ----------------------------------------------------------------------------
// interpolated fractional delay: assertion macros
// shared property forms used by the delay line modules
// ----------------------------------------------------------------------------
`ifndef INTERPOLATED_FRACTIONAL_DELAY_TOP_DEFINES_SVH
`define INTERPOLATED_FRACTIONAL_DELAY_TOP_DEFINES_SVH

// same-cycle implication
`define IFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// ifd_pkg
// widths, constants and shared types of the interpolated fractional delay
// ----------------------------------------------------------------------------
package ifd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DELAY_W  = 11;
    localparam int FRAC_W   = 15;
    localparam int CFG_W    = 12;

    // ring length after reset
    localparam int LEN_RESET = 2048;

    // unity weight in q15
    localparam logic [FRAC_W-1:0] FRAC_ONE = 15'h7FFF;

    // result buffer
    localparam int OBUF_AW    = 2;
    localparam int OBUF_DEPTH = 1 << OBUF_AW;
    localparam int OBUF_CW    = OBUF_AW + 1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // per item sequencing: idle, read newer tap, read older tap and write
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RDA  = 3'b010,
        ST_RDB  = 3'b100
    } t_stage;

    // command to the interpolator, valid in the cycle the newer tap arrives
    typedef struct packed {
        logic              first;
        logic [FRAC_W-1:0] frac;
    } t_mac_cmd;

endpackage

// ===== rtl/ifd_ifs.sv =====
// ----------------------------------------------------------------------------
// ifd stream interfaces
// input word and result word channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface ifd_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [ifd_pkg::SAMPLE_W-1:0] sample_in;
    logic [ifd_pkg::DELAY_W-1:0]        delay_whole;
    logic [ifd_pkg::FRAC_W-1:0]         delay_fraction;

    modport source (output valid, sample_in, delay_whole, delay_fraction, input ready);
    modport sink   (input valid, sample_in, delay_whole, delay_fraction, output ready);
endinterface

interface ifd_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ifd_pkg::SAMPLE_W-1:0] delayed_out;

    modport source (output valid, delayed_out, input ready);
    modport sink   (input valid, delayed_out, output ready);
endinterface

// ===== rtl/ifd_store.sv =====
// ----------------------------------------------------------------------------
// ifd_store
// sample ring memory: one write port, one registered read port, and a
// zeroing sweep over every entry after reset
// ----------------------------------------------------------------------------
module ifd_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  ifd_pkg::t_sample      i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output ifd_pkg::t_sample      o_rdata,
    output logic                  o_busy
);

    logic [ifd_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [ifd_pkg::SAMPLE_W-1:0] r_rdata;
    logic                         r_clr;
    logic [AW-1:0]                r_clr_idx;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [ifd_pkg::SAMPLE_W-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_clr) begin
            r_clr_idx <= r_clr_idx + AW'(1);
            if (r_clr_idx == AW'(DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    // the sweep owns the write port until it is done
    always_comb begin
        wr_en   = r_clr | i_we;
        wr_addr = r_clr ? r_clr_idx : i_waddr;
        wr_data = r_clr ? '0 : i_wdata;
    end

    // read returns the old word when the same entry is written
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr;

endmodule

// ===== rtl/ifd_interp.sv =====
// ----------------------------------------------------------------------------
// ifd_interp
// linear interpolation of two taps through one shared q15 multiplier
// ----------------------------------------------------------------------------
`include "interpolated_fractional_delay_top_defines.svh"

module ifd_interp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ifd_pkg::t_mac_cmd    i_cmd,
    input  ifd_pkg::t_sample     i_rd_data,
    output logic                 o_vld,
    output ifd_pkg::t_sample     o_res
);

    logic [ifd_pkg::FRAC_W-1:0]   r_frac;
    logic [ifd_pkg::SAMPLE_W-1:0] r_t0;
    logic [ifd_pkg::SAMPLE_W-1:0] r_t1;
    logic                         r_sv1;
    logic                         r_sv2;

    logic [ifd_pkg::FRAC_W-1:0]   weight;
    logic signed [31:0]           prod;
    logic [ifd_pkg::SAMPLE_W-1:0] q15;

    // newer tap takes 1 - frac, older tap the next cycle takes frac
    always_comb begin
        weight = i_cmd.first ? (ifd_pkg::FRAC_ONE - i_cmd.frac) : r_frac;
        prod   = $signed(i_rd_data) * $signed({1'b0, weight});
        // weight is never negative, so floor shift fits 16 bits without saturation
        q15    = prod[30:15];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.first) begin
            r_t1   <= q15;
            r_frac <= i_cmd.frac;
        end
        if (r_sv1) begin
            r_t0 <= q15;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv1 <= 1'b0;
            r_sv2 <= 1'b0;
        end else begin
            r_sv1 <= i_cmd.first;
            r_sv2 <= r_sv1;
        end
    end

    assign o_vld = r_sv2;
    assign o_res = $signed(r_t0 + r_t1);

    `IFD_ASSERT_IMP(a_mul_no_overlap, i_clk, i_rst_n, i_cmd.first, !r_sv1, "multiplier claimed by two taps")

endmodule

// ===== rtl/ifd_obuf.sv =====
// ----------------------------------------------------------------------------
// ifd_obuf
// small result queue that decouples the pipeline from the output handshake
// ----------------------------------------------------------------------------
`include "interpolated_fractional_delay_top_defines.svh"

module ifd_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ifd_pkg::t_sample  i_data,
    ifd_out_if.source         o_out
);

    logic [ifd_pkg::SAMPLE_W-1:0] r_mem [ifd_pkg::OBUF_DEPTH];
    logic [ifd_pkg::OBUF_AW-1:0]  r_wp;
    logic [ifd_pkg::OBUF_AW-1:0]  r_rp;
    logic [ifd_pkg::OBUF_CW-1:0]  r_cnt;
    logic                         pop;

    assign pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + ifd_pkg::OBUF_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + ifd_pkg::OBUF_AW'(1);
            end
            r_cnt <= r_cnt + ifd_pkg::OBUF_CW'(i_push) - ifd_pkg::OBUF_CW'(pop);
        end
    end

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.delayed_out = $signed(r_mem[r_rp]);

    `IFD_ASSERT_IMP(a_obuf_no_overflow, i_clk, i_rst_n, i_push, (r_cnt < ifd_pkg::OBUF_CW'(ifd_pkg::OBUF_DEPTH)) || pop, "result queue overflow")

endmodule

// ===== rtl/interpolated_fractional_delay_top.sv =====
// ----------------------------------------------------------------------------
// interpolated fractional delay line
// Takes no word while the newer tap is read: both interpolation taps come out of
// the single read port of the sample memory, the newer tap in ST_RDA and
// the older tap in ST_RDB, where the new sample is also written and the next
// word may be accepted. A result passes the read register and the two tap
// registers and waits in a 4-entry queue, so input keeps flowing while output
// stalls until 4 words are in flight.
// After reset the memory is zeroed one entry a cycle, and no word is accepted
// until that is done; delay_length may be written at any time the line is
// idle.
// ----------------------------------------------------------------------------
`include "interpolated_fractional_delay_top_defines.svh"

module interpolated_fractional_delay_top #(
    parameter int STORE_DEPTH = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ifd_pkg::CFG_W-1:0]   i_cfg_wdata,
    ifd_in_if.sink                      i_in,
    ifd_out_if.source                   o_out
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = AW + 1;
    localparam int XW = (LW > ifd_pkg::CFG_W) ? LW : ifd_pkg::CFG_W;
    localparam logic [LW-1:0] LEN_RST =
        LW'((ifd_pkg::LEN_RESET > STORE_DEPTH) ? STORE_DEPTH : ifd_pkg::LEN_RESET);

    ifd_pkg::t_stage              r_st, n_st;
    logic [LW-1:0]                r_len;
    logic [AW-1:0]                r_wr_idx;
    logic [AW-1:0]                r_delay;
    logic [ifd_pkg::FRAC_W-1:0]   r_frac;
    logic [ifd_pkg::SAMPLE_W-1:0] r_samp;
    logic [AW-1:0]                r_a_idx;
    logic [AW-1:0]                r_w_eff;
    logic [ifd_pkg::OBUF_CW-1:0]  r_inflight;

    logic [LW-1:0]                n_len;
    logic [XW-1:0]                cfg_x;
    logic [XW-1:0]                len_x;
    logic [XW-1:0]                in_d_x;
    logic [XW-1:0]                dly_cl;
    logic [XW-1:0]                w_x;
    logic [XW-1:0]                w_eff;
    logic [XW-1:0]                d_x;
    logic [XW-1:0]                a_x;
    logic [XW-1:0]                older_x;
    logic [XW-1:0]                wnx_x;
    logic [XW-1:0]                w_nx;

    logic                         acc;
    logic                         take;
    logic                         clr_busy;
    logic [AW-1:0]                rd_addr;
    logic                         mem_we;
    ifd_pkg::t_sample             rd_data;
    ifd_pkg::t_mac_cmd            mac_cmd;
    logic                         res_vld;
    ifd_pkg::t_sample             res;

    // ring length, clamped once when written
    always_comb begin
        cfg_x = XW'(i_cfg_wdata);
        priority if (cfg_x < XW'(2)) begin
            n_len = LW'(2);
        end else if (cfg_x > XW'(STORE_DEPTH)) begin
            n_len = LW'(STORE_DEPTH);
        end else begin
            n_len = cfg_x[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RST;
        end else if (i_cfg_we) begin
            r_len <= n_len;
        end
    end

    assign len_x = XW'(r_len);

    // handshake
    assign i_in.ready = !clr_busy && (r_st != ifd_pkg::ST_RDA) &&
                        (r_inflight < ifd_pkg::OBUF_CW'(ifd_pkg::OBUF_DEPTH));
    assign acc  = i_in.valid && i_in.ready;
    assign take = o_out.valid && o_out.ready;

    // delay clamp on the way in
    always_comb begin
        in_d_x = XW'(i_in.delay_whole);
        dly_cl = (in_d_x >= len_x) ? (len_x - XW'(1)) : in_d_x;
    end

    // newer tap address
    always_comb begin
        w_x   = XW'(r_wr_idx);
        w_eff = (w_x >= len_x) ? '0 : w_x;
        d_x   = XW'(r_delay);
        a_x   = (w_eff >= d_x) ? (w_eff - d_x) : (w_eff + len_x - d_x);
    end

    // older tap address and next write slot
    always_comb begin
        older_x = (r_a_idx == '0) ? (len_x - XW'(1)) : (XW'(r_a_idx) - XW'(1));
        wnx_x   = XW'(r_w_eff) + XW'(1);
        w_nx    = (wnx_x >= len_x) ? '0 : wnx_x;
    end

    assign rd_addr = (r_st == ifd_pkg::ST_RDB) ? older_x[AW-1:0] : a_x[AW-1:0];
    assign mem_we  = (r_st == ifd_pkg::ST_RDB);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ifd_pkg::ST_IDLE: begin
                if (acc) begin
                    n_st = ifd_pkg::ST_RDA;
                end
            end
            ifd_pkg::ST_RDA: begin
                n_st = ifd_pkg::ST_RDB;
            end
            ifd_pkg::ST_RDB: begin
                n_st = acc ? ifd_pkg::ST_RDA : ifd_pkg::ST_IDLE;
            end
            default: begin
                n_st = ifd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ifd_pkg::ST_IDLE;
            r_wr_idx   <= '0;
            r_inflight <= '0;
        end else begin
            r_st       <= n_st;
            r_inflight <= r_inflight + ifd_pkg::OBUF_CW'(acc) - ifd_pkg::OBUF_CW'(take);
            if (mem_we) begin
                r_wr_idx <= w_nx[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_samp  <= i_in.sample_in;
            r_delay <= dly_cl[AW-1:0];
            r_frac  <= i_in.delay_fraction;
        end
        if (r_st == ifd_pkg::ST_RDA) begin
            r_a_idx <= a_x[AW-1:0];
            r_w_eff <= w_eff[AW-1:0];
        end
    end

    ifd_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (w_nx[AW-1:0]),
        .i_wdata ($signed(r_samp)),
        .i_raddr (rd_addr),
        .o_rdata (rd_data),
        .o_busy  (clr_busy)
    );

    // newer tap data is on the read port during the write cycle
    assign mac_cmd.first = (r_st == ifd_pkg::ST_RDB);
    assign mac_cmd.frac  = r_frac;

    ifd_interp u_interp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mac_cmd),
        .i_rd_data (rd_data),
        .o_vld     (res_vld),
        .o_res     (res)
    );

    ifd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_data  (res),
        .o_out   (o_out)
    );

    `IFD_ASSERT_NXT(a_widx_in_ring, i_clk, i_rst_n, r_st == ifd_pkg::ST_RDB, XW'(r_wr_idx) < len_x, "write index left the ring")
    `IFD_ASSERT_IMP(a_read_in_ring, i_clk, i_rst_n, r_st == ifd_pkg::ST_RDA, a_x < len_x, "tap address outside the ring")
    `IFD_ASSERT_IMP(a_inflight_bound, i_clk, i_rst_n, 1'b1, r_inflight <= ifd_pkg::OBUF_CW'(ifd_pkg::OBUF_DEPTH), "too many words in flight")
    `IFD_ASSERT_NXT(a_accept_reads, i_clk, i_rst_n, acc, r_st == ifd_pkg::ST_RDA, "accepted word did not start its reads")

endmodule

// ===== bench/tb_interpolated_fractional_delay_top.sv =====
// ----------------------------------------------------------------------------
// tb_interpolated_fractional_delay_top
// Drives words into the fractional delay line and checks every interpolated
// result against a predictor that keeps its own copy of the sample ring,
// the write index and the ring length. It runs a directed part and then
// random phases at several ring lengths, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_interpolated_fractional_delay_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 2048;
    localparam int STALL_LIMIT = 20000;
    localparam int N_PHASES    = 11;
    localparam int LEN_SMALL   = -1;
    localparam int LEN_ANY     = -2;

    typedef struct packed {
        ifd_pkg::t_sample            sample;
        logic [ifd_pkg::DELAY_W-1:0] dly;
        logic [ifd_pkg::FRAC_W-1:0]  frac;
    } t_delay_word;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      cfg_we      = 1'b0;
    logic [ifd_pkg::CFG_W-1:0] cfg_wdata   = '0;
    logic                      drv_valid   = 1'b0;
    t_delay_word               drv_word    = '0;
    logic                      sink_ready  = 1'b0;
    bit                        steady      = 1'b0;

    t_delay_word      pending_words[$];
    ifd_pkg::t_sample expected_outputs[$];
    ifd_pkg::t_sample oldest_out;
    int               mismatch_count = 0;
    int               stall_cycles   = 0;

    // predictor state
    ifd_pkg::t_sample ring_store[STORE_DEPTH] = '{default: '0};
    int               ring_wr_idx  = 0;
    int               ring_len_cfg = ifd_pkg::LEN_RESET;

    // ring length per random phase, negative codes pick a random length
    int length_plan[N_PHASES] = '{0, 1, 2, 3, 4095, 2048, 2047, LEN_SMALL, LEN_ANY, 16, LEN_ANY};
    int count_plan[N_PHASES]  = '{60, 40, 60, 60, 80, 150, 60, 80, 80, 60, 70};
    localparam int STEADY_PHASE = 5;

    ifd_in_if  in_bus ();
    ifd_out_if out_bus ();

    assign in_bus.valid          = drv_valid;
    assign in_bus.sample_in      = drv_word.sample;
    assign in_bus.delay_whole    = drv_word.dly;
    assign in_bus.delay_fraction = drv_word.frac;
    assign out_bus.ready         = sink_ready;

    interpolated_fractional_delay_top #(
        .STORE_DEPTH (STORE_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    always #2 i_clk = ~i_clk;

    function automatic int ring_length();
        if (ring_len_cfg < 2) return 2;
        if (ring_len_cfg > STORE_DEPTH) return STORE_DEPTH;
        return ring_len_cfg;
    endfunction

    function automatic int q15_product(ifd_pkg::t_sample x, int y);
        if (x == -32768 && y == -32768) return 32767;
        return (int'(x) * y) >>> 15;
    endfunction

    // reads both taps, then advances the write index and stores the sample
    function automatic ifd_pkg::t_sample predict_delayed(t_delay_word w);
        int          len;
        int          wr;
        int          dly;
        int          rd_new;
        int          rd_old;
        int          t_old;
        int          t_new;
        logic [15:0] total;
        len = ring_length();
        wr  = ring_wr_idx;
        if (wr >= len) wr = 0;
        dly = int'(w.dly);
        if (dly >= len) dly = len - 1;
        rd_new = (wr >= dly) ? wr - dly : wr + len - dly;
        rd_old = (rd_new == 0) ? len - 1 : rd_new - 1;
        t_old  = q15_product(ring_store[rd_old], int'(w.frac));
        t_new  = q15_product(ring_store[rd_new], int'(ifd_pkg::FRAC_ONE) - int'(w.frac));
        total  = 16'(t_old + t_new);
        wr = (wr + 1 >= len) ? 0 : wr + 1;
        ring_store[wr] = w.sample;
        ring_wr_idx    = wr;
        return ifd_pkg::t_sample'(total);
    endfunction

    task automatic push_word(int sample, int dly, int frac);
        t_delay_word w;
        w.sample = ifd_pkg::t_sample'(sample);
        w.dly    = ifd_pkg::DELAY_W'(dly);
        w.frac   = ifd_pkg::FRAC_W'(frac);
        pending_words.push_back(w);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || drv_valid || expected_outputs.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_length(int value);
        repeat (8) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ifd_pkg::CFG_W'(value);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        ring_len_cfg = value;
        @(negedge i_clk);
    endtask

    task automatic add_random_words(int count);
        int len;
        int sample;
        int dly;
        int frac;
        len = ring_length();
        repeat (count) begin
            case ($urandom_range(0, 9))
                0:       sample = 32767;
                1:       sample = -32768;
                default: sample = int'(ifd_pkg::t_sample'($urandom));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: dly = $urandom_range(0, len - 1);
                5:             dly = 0;
                6:             dly = len - 1;
                7:             dly = $urandom_range(0, 2047);
                default:       dly = $urandom_range(0, 7);
            endcase
            case ($urandom_range(0, 9))
                8:       frac = 0;
                9:       frac = 32767;
                default: frac = $urandom_range(0, 32767);
            endcase
            push_word(sample, dly, frac);
        end
    endtask

    // sender: predicts at acceptance and presents the next pending word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && in_bus.ready)
                expected_outputs.push_back(predict_delayed(drv_word));
            if (!drv_valid || in_bus.ready) begin
                if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 11)) begin
                    drv_word  <= pending_words.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: compares each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (out_bus.valid && sink_ready) begin
                if (expected_outputs.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result word: delayed_out %0d", out_bus.delayed_out);
                    mismatch_count++;
                end else begin
                    oldest_out = expected_outputs.pop_front();
                    if (out_bus.delayed_out !== oldest_out) begin
                        if (mismatch_count < 10)
                            $display("mismatch: delayed_out expected %0d got %0d",
                                     oldest_out, out_bus.delayed_out);
                        mismatch_count++;
                    end
                end
            end
            sink_ready <= steady || ($urandom_range(0, 99) >= 11);
        end
    end

    always @(posedge i_clk) begin
        if ((drv_valid && in_bus.ready) || (out_bus.valid && sink_ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int len;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset length: extremes, read at ring start, most negative taps
        push_word(32767, 0, 0);
        push_word(-32768, 0, 32767);
        push_word(-1, 1, 16384);
        push_word(0, 2047, 32767);
        push_word(12345, 4, 0);
        push_word(-32768, 3, 1);
        push_word(32767, 1, 32767);
        push_word(-32768, 2, 0);
        push_word(-32768, 1, 32766);
        push_word(1, 1, 16383);
        push_word(-2, 9, 1000);
        push_word(32767, 0, 32767);
        wait_drained();

        // shorter ring: stale write index, clamped delays, ring start
        write_length(4);
        push_word(100, 0, 32767);
        push_word(-32768, 2047, 0);
        push_word(32767, 4, 32767);
        push_word(-300, 3, 20000);
        push_word(7, 0, 5);
        push_word(-32768, 1, 32767);
        push_word(32767, 2, 12);
        push_word(-1, 3, 0);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            len = length_plan[p];
            if (len == LEN_SMALL) len = $urandom_range(5, 64);
            if (len == LEN_ANY) len = $urandom_range(0, 4095);
            write_length(len);
            steady = (p == STEADY_PHASE);
            add_random_words(count_plan[p]);
            wait_drained();
            steady = 1'b0;
        end

        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && expected_outputs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
